>>> design/acs_pkg.sv
`timescale 1ns / 1ps

package acs_pkg;

	// Fixed field widths
	localparam int ADDR_W = 10;
	localparam int DATA_W = 8;
	localparam int CMD_W  = 2;

	// Default sizing
	localparam int MEM_BYTES_DEF    = 516;
	localparam int HEADER_BYTES_DEF = 4;

	// Transaction commands
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd2;

	// Instruction opcodes
	localparam logic [DATA_W-1:0] OPC_STA = 8'h10;
	localparam logic [DATA_W-1:0] OPC_LDA = 8'h20;
	localparam logic [DATA_W-1:0] OPC_ADD = 8'h30;
	localparam logic [DATA_W-1:0] OPC_SUB = 8'h31;
	localparam logic [DATA_W-1:0] OPC_OR  = 8'h40;
	localparam logic [DATA_W-1:0] OPC_AND = 8'h50;
	localparam logic [DATA_W-1:0] OPC_NOT = 8'h60;
	localparam logic [DATA_W-1:0] OPC_JMP = 8'h80;
	localparam logic [DATA_W-1:0] OPC_JMN = 8'h90;
	localparam logic [DATA_W-1:0] OPC_JMZ = 8'hA0;
	localparam logic [DATA_W-1:0] OPC_HLT = 8'hF0;

	// Memory access request from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

>>> design/acs_if.sv
`timescale 1ns / 1ps

interface acs_in_if import acs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  op;
	logic [ADDR_W-1:0] mem_address;
	logic [DATA_W-1:0] write_data;

	modport source(output valid, op, mem_address, write_data, input ready);
	modport sink(input valid, op, mem_address, write_data, output ready);
endinterface

interface acs_out_if import acs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [DATA_W-1:0] accumulator;
	logic [ADDR_W-1:0] program_counter;
	logic              halted;
	logic              negative_flag;
	logic              zero_flag;

	modport source(output valid, read_data, accumulator, program_counter, halted,
		negative_flag, zero_flag, input ready);
	modport sink(input valid, read_data, accumulator, program_counter, halted,
		negative_flag, zero_flag, output ready);
endinterface

>>> design/acs_mem.sv
`timescale 1ns / 1ps

module acs_mem import acs_pkg::*; #(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [DATA_W-1:0] rdata,
	output logic              busy
);

	localparam int              IDX_W = $clog2(MEM_BYTES);
	localparam logic [ADDR_W:0] LIMIT = (ADDR_W+1)'(MEM_BYTES);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(MEM_BYTES - 1);

	logic [DATA_W-1:0] mem [MEM_BYTES];

	logic [IDX_W-1:0]  clr_idx_q;
	logic              clr_q;
	logic              w_ok;
	logic              r_ok;
	logic [DATA_W-1:0] mem_rd_q;
	logic              ok_q;
	logic              fwd_q;
	logic [DATA_W-1:0] fwd_data_q;

	// Range checks: out-of-range writes drop, reads return zero
	assign w_ok = {1'b0, req.waddr} < LIMIT;
	assign r_ok = {1'b0, req.raddr} < LIMIT;

	// Sweep zeros through the array after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign busy = clr_q;

	// Write port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (req.we && w_ok) begin
			mem[req.waddr[IDX_W-1:0]] <= req.wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (req.re && r_ok) begin
			mem_rd_q <= mem[req.raddr[IDX_W-1:0]];
		end
	end

	// Capture range and write-to-read forwarding alongside the read
	always_ff @(posedge clk) begin
		if (req.re) begin
			ok_q       <= r_ok;
			fwd_q      <= req.we && w_ok && (req.waddr == req.raddr);
			fwd_data_q <= req.wdata;
		end
	end

	always_comb begin
		if (!ok_q) begin
			rdata = '0;
		end else if (fwd_q) begin
			rdata = fwd_data_q;
		end else begin
			rdata = mem_rd_q;
		end
	end

endmodule

>>> design/acs_ctrl.sv
`timescale 1ns / 1ps

module acs_ctrl import acs_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	acs_in_if.sink            cmd,
	acs_out_if.source         rsp,
	output mem_req_t          mem_req,
	input  logic [DATA_W-1:0] mem_rdata,
	input  logic              mem_busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDATA = 3'd1;
	localparam logic [2:0] ST_OPC   = 3'd2;
	localparam logic [2:0] ST_OPND  = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;
	localparam logic [2:0] ST_HALT  = 3'd5;

	logic [2:0]        state_q;
	logic [DATA_W-1:0] acc_q;
	logic [ADDR_W-1:0] pc_q;
	logic [DATA_W-1:0] opc_q;
	logic [ADDR_W-1:0] ea_q;
	logic [DATA_W-1:0] rd_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_rd_q;
	logic [DATA_W-1:0] out_acc_q;
	logic [ADDR_W-1:0] out_pc_q;
	logic              out_halt_q;

	logic              accept;
	logic              load_out;
	logic              is_hlt;
	logic [ADDR_W-1:0] pc2;
	logic [ADDR_W-1:0] pc4;
	logic [ADDR_W-1:0] ea_calc;
	logic [DATA_W-1:0] acc_nx;
	logic [ADDR_W-1:0] pc_nx;
	logic              sta;

	assign cmd.ready = (state_q == ST_IDLE) && !mem_busy;
	assign accept    = cmd.valid && cmd.ready;
	assign load_out  = (state_q == ST_HALT) && (!out_valid_q || rsp.ready);
	assign is_hlt    = mem_rdata == OPC_HLT;
	assign pc2       = pc_q + ADDR_W'(2);
	assign pc4       = pc_q + ADDR_W'(4);
	assign ea_calc   = {1'b0, mem_rdata, 1'b0} + ADDR_W'(HEADER_BYTES);

	// Execute the fetched instruction against the operand data
	always_comb begin
		acc_nx = acc_q;
		pc_nx  = pc4;
		sta    = 1'b0;
		case (opc_q)
			OPC_STA: sta = 1'b1;
			OPC_LDA: acc_nx = mem_rdata;
			OPC_ADD: acc_nx = acc_q + mem_rdata;
			OPC_SUB: acc_nx = acc_q - mem_rdata;
			OPC_OR:  acc_nx = acc_q | mem_rdata;
			OPC_AND: acc_nx = acc_q & mem_rdata;
			OPC_NOT: begin
				acc_nx = ~acc_q;
				pc_nx  = pc2;
			end
			OPC_JMP: pc_nx = ea_q;
			OPC_JMN: begin
				if (acc_q[DATA_W-1]) begin
					pc_nx = ea_q;
				end
			end
			OPC_JMZ: begin
				if (acc_q == '0) begin
					pc_nx = ea_q;
				end
			end
			default: ;
		endcase
	end

	// Issue memory accesses per step
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						CMD_WRITE: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = cmd.mem_address;
							mem_req.wdata = cmd.write_data;
							mem_req.re    = 1'b1;
							mem_req.raddr = pc_q;
						end
						CMD_READ: begin
							mem_req.re    = 1'b1;
							mem_req.raddr = cmd.mem_address;
						end
						default: begin
							mem_req.re    = 1'b1;
							mem_req.raddr = pc_q;
						end
					endcase
				end
			end
			ST_RDATA: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = pc_q;
			end
			ST_OPC: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = is_hlt ? pc_q : pc2;
			end
			ST_OPND: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = ea_calc;
			end
			ST_EXEC: begin
				mem_req.we    = sta;
				mem_req.waddr = ea_q;
				mem_req.wdata = acc_q;
				mem_req.re    = 1'b1;
				mem_req.raddr = pc_nx;
			end
			ST_HALT: ;
			default: ;
		endcase
	end

	// Advance the sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.op == CMD_READ) begin
							state_q <= ST_RDATA;
						end else if (cmd.op == CMD_EXEC) begin
							state_q <= ST_OPC;
						end else begin
							state_q <= ST_HALT;
						end
					end
				end
				ST_RDATA: state_q <= ST_HALT;
				ST_OPC:   state_q <= is_hlt ? ST_HALT : ST_OPND;
				ST_OPND:  state_q <= ST_EXEC;
				ST_EXEC: begin
					acc_q   <= acc_nx;
					pc_q    <= pc_nx;
					state_q <= ST_HALT;
				end
				ST_HALT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold per-transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= '0;
		end
		if (state_q == ST_RDATA) begin
			rd_q <= mem_rdata;
		end
		if (state_q == ST_OPC) begin
			opc_q <= mem_rdata;
		end
		if (state_q == ST_OPND) begin
			ea_q <= ea_calc;
		end
		if (load_out) begin
			out_rd_q   <= rd_q;
			out_acc_q  <= acc_q;
			out_pc_q   <= pc_q;
			out_halt_q <= is_hlt;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.read_data       = out_rd_q;
	assign rsp.accumulator     = out_acc_q;
	assign rsp.program_counter = out_pc_q;
	assign rsp.halted          = out_halt_q;
	assign rsp.negative_flag   = out_acc_q[DATA_W-1];
	assign rsp.zero_flag       = out_acc_q == '0;

endmodule

>>> design/accumulator_cpu_step.sv
// Execute transaction: the opcode, operand and data reads are dependent and share the single
// read port, so they run in turn (states OPC, OPND, EXEC); a halt opcode ends after OPC.
// Read transaction: one data read in state RDATA; write or unused: no further read state.
// A pending result sits in an output register while the next transaction is taken.
// After reset the memory is zeroed by a sweep over all MEM_BYTES bytes (516 by default);
// no transaction is accepted until it ends. Accumulator and program counter reset to zero.
`timescale 1ns / 1ps

module accumulator_cpu_step import acs_pkg::*; #(
	parameter int MEM_BYTES    = MEM_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	acs_in_if.sink    cmd,
	acs_out_if.source rsp
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] mem_rdata;
	logic              mem_busy;

	acs_mem #(
		.MEM_BYTES(MEM_BYTES)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (mem_rdata),
		.busy  (mem_busy)
	);

	acs_ctrl #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.mem_req  (mem_req),
		.mem_rdata(mem_rdata),
		.mem_busy (mem_busy)
	);

endmodule
